/* rtl/u8cut_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// u8cut_pkg
// Shared types, codes and constants for the UTF-8 prefix cutter.
// ----------------------------------------------------------------------------
package u8cut_pkg;

    // Width of the internal kept-length counter
    localparam int LEN_WIDTH     = 16;
    localparam int LEN_EXT_WIDTH = (LEN_WIDTH > 16) ? LEN_WIDTH : 16;
    localparam int FIELD_WIDTH   = 16;

    localparam logic [FIELD_WIDTH-1:0] FIELD_MAX = '1;
    localparam logic [LEN_WIDTH-1:0]   LEN_MAX   = '1;

    // Stop causes
    localparam logic [1:0] CAUSE_END     = 2'd0;
    localparam logic [1:0] CAUSE_LIMIT   = 2'd1;
    localparam logic [1:0] CAUSE_INVALID = 2'd2;
    localparam logic [1:0] CAUSE_TRUNC   = 2'd3;

    // Byte class boundaries
    localparam logic [7:0] ASCII_MAX = 8'h7F;
    localparam logic [7:0] LEAD2_MIN = 8'hC0;
    localparam logic [7:0] LEAD2_MAX = 8'hDF;
    localparam logic [7:0] LEAD3_MIN = 8'hE0;
    localparam logic [7:0] LEAD3_MAX = 8'hEF;
    localparam logic [7:0] LEAD4_MIN = 8'hF0;
    localparam logic [7:0] LEAD4_MAX = 8'hF7;
    localparam logic [7:0] CONT_MIN  = 8'h80;
    localparam logic [7:0] CONT_MAX  = 8'hBF;

    typedef struct packed {
        logic                   stopped;
        logic [1:0]             cont_remaining;
        logic [2:0]             char_bytes_pending;
        logic [LEN_WIDTH-1:0]   committed_length;
        logic [FIELD_WIDTH-1:0] char_count;
        logic [1:0]             stop_reason;
    } walk_state_t;

    // Registered input byte
    typedef struct packed {
        logic       valid;
        logic [7:0] text_byte;
        logic       last_byte;
    } byte_item_t;

    typedef struct packed {
        logic [FIELD_WIDTH-1:0] kept_bytes;
        logic [FIELD_WIDTH-1:0] kept_chars;
        logic [1:0]             stop_cause;
    } cut_result_t;

endpackage : u8cut_pkg
`default_nettype wire

/* rtl/u8cut_in_reg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// u8cut_in_reg
// Input register for the byte stream, with stall back to the sender.
// ----------------------------------------------------------------------------
module u8cut_in_reg (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                text_valid,
    output logic                     text_stall,
    input  wire logic [7:0]          text_byte,
    input  wire logic                last_byte,
    input  wire logic                res_free,
    output logic                     go,
    output u8cut_pkg::byte_item_t    item
);
    import u8cut_pkg::*;

    logic       valid_reg,  valid_next;
    logic [7:0] byte_reg,   byte_next;
    logic       last_reg,   last_next;
    logic       load;

    // A final byte moves on only when the result register has room
    assign go         = valid_reg && (!last_reg || res_free);
    assign text_stall = valid_reg && !go;
    assign load       = text_valid && !text_stall;

    always_comb
    begin
        valid_next = load ? 1'b1 : (go ? 1'b0 : valid_reg);
        byte_next  = load ? text_byte : byte_reg;
        last_next  = load ? last_byte : last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

    assign item = '{valid: valid_reg, text_byte: byte_reg, last_byte: last_reg};

endmodule : u8cut_in_reg
`default_nettype wire

/* rtl/u8cut_walker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// u8cut_walker
// Per-byte UTF-8 walk: character state, counters and stop cause.
// ----------------------------------------------------------------------------
module u8cut_walker (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  go,
    input  wire u8cut_pkg::byte_item_t                 item,
    input  wire logic [u8cut_pkg::FIELD_WIDTH-1:0]     char_limit,
    output u8cut_pkg::cut_result_t                     result
);
    import u8cut_pkg::*;

    walk_state_t state_reg, state_next;
    walk_state_t upd;

    logic                   commit;
    logic [2:0]             commit_len;
    logic [2:0]             pend_inc;
    logic [1:0]             cont_dec;
    logic [LEN_WIDTH:0]     len_sum;
    logic [LEN_EXT_WIDTH-1:0] len_ext;
    logic [7:0]             b;

    assign b = item.text_byte;

    always_comb
    begin
        upd        = state_reg;
        commit     = 1'b0;
        commit_len = 3'd1;
        pend_inc   = state_reg.char_bytes_pending + 3'd1;
        cont_dec   = state_reg.cont_remaining - 2'd1;
        len_sum    = '0;

        if (!state_reg.stopped)
        begin
            if (state_reg.cont_remaining == 2'd0)
            begin
                priority if (b <= ASCII_MAX)
                begin
                    commit     = 1'b1;
                    commit_len = 3'd1;
                end
                else if (b >= LEAD2_MIN && b <= LEAD2_MAX)
                begin
                    upd.cont_remaining     = 2'd1;
                    upd.char_bytes_pending = 3'd1;
                end
                else if (b >= LEAD3_MIN && b <= LEAD3_MAX)
                begin
                    upd.cont_remaining     = 2'd2;
                    upd.char_bytes_pending = 3'd1;
                end
                else if (b >= LEAD4_MIN && b <= LEAD4_MAX)
                begin
                    upd.cont_remaining     = 2'd3;
                    upd.char_bytes_pending = 3'd1;
                end
                else
                begin
                    upd.stopped     = 1'b1;
                    upd.stop_reason = CAUSE_INVALID;
                end
            end
            else if (b >= CONT_MIN && b <= CONT_MAX)
            begin
                upd.char_bytes_pending = pend_inc;
                upd.cont_remaining     = cont_dec;
                if (cont_dec == 2'd0)
                begin
                    commit     = 1'b1;
                    commit_len = pend_inc;
                end
            end
            else
            begin
                upd.stopped     = 1'b1;
                upd.stop_reason = CAUSE_INVALID;
            end
        end

        // Whole character: add its bytes, bump the count, check the limit
        if (commit)
        begin
            len_sum = {1'b0, state_reg.committed_length} + (LEN_WIDTH+1)'(commit_len);
            upd.committed_length   = len_sum[LEN_WIDTH] ? LEN_MAX : len_sum[LEN_WIDTH-1:0];
            if (state_reg.char_count != FIELD_MAX)
            begin
                upd.char_count = state_reg.char_count + FIELD_WIDTH'(1);
            end
            upd.cont_remaining     = 2'd0;
            upd.char_bytes_pending = 3'd0;
            if (char_limit <= upd.char_count)
            begin
                upd.stopped     = 1'b1;
                upd.stop_reason = CAUSE_LIMIT;
            end
        end

        // Final byte: result taken from the updated state, then a fresh string
        state_next = item.last_byte ? '0 : upd;
    end

    always_comb
    begin
        len_ext = LEN_EXT_WIDTH'(upd.committed_length);
        result.kept_bytes = (len_ext > LEN_EXT_WIDTH'(FIELD_MAX)) ? FIELD_MAX
                                                                   : len_ext[FIELD_WIDTH-1:0];
        result.kept_chars = upd.char_count;
        if (upd.stopped)
        begin
            result.stop_cause = upd.stop_reason;
        end
        else if (upd.cont_remaining != 2'd0)
        begin
            result.stop_cause = CAUSE_TRUNC;
        end
        else
        begin
            result.stop_cause = CAUSE_END;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (go)
        begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTHESIS
    // Between characters nothing is pending unless the walk has stopped
    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (!state_reg.stopped && state_reg.cont_remaining == 2'd0)
            |-> (state_reg.char_bytes_pending == 3'd0))
        else $error("pending bytes without open character");

    // A character never holds more than four bytes
    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.char_bytes_pending + 3'(state_reg.cont_remaining)) <= 3'd4)
        else $error("character length out of range");

    // Within a string the character count never goes down
    a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (go && !item.last_byte) |=> (state_reg.char_count >= $past(state_reg.char_count)))
        else $error("character count decreased mid-string");
`endif

endmodule : u8cut_walker
`default_nettype wire

/* rtl/u8cut_out_reg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// u8cut_out_reg
// Result register holding one request until the receiver takes it.
// ----------------------------------------------------------------------------
module u8cut_out_reg (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                load,
    input  wire u8cut_pkg::cut_result_t              result,
    output logic                                     res_free,
    output logic                                     result_valid,
    input  wire logic                                result_stall,
    output logic [u8cut_pkg::FIELD_WIDTH-1:0]        kept_bytes,
    output logic [u8cut_pkg::FIELD_WIDTH-1:0]        kept_chars,
    output logic [1:0]                               stop_cause
);
    import u8cut_pkg::*;

    logic        valid_reg, valid_next;
    cut_result_t data_reg,  data_next;

    assign res_free = !valid_reg || !result_stall;

    always_comb
    begin
        valid_next = load ? 1'b1 : (valid_reg && result_stall);
        data_next  = load ? result : data_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign result_valid = valid_reg;
    assign kept_bytes   = data_reg.kept_bytes;
    assign kept_chars   = data_reg.kept_chars;
    assign stop_cause   = data_reg.stop_cause;

endmodule : u8cut_out_reg
`default_nettype wire

/* rtl/utf8_prefix_cut_by_char_limit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_prefix_cut_by_char_limit
// Walks a UTF-8 byte stream and reports the prefix kept under a char limit.
// ----------------------------------------------------------------------------
// One byte is taken per cycle while no final byte is stalled; a byte passes
// through the input register and is folded into the walk state as it leaves
// it, so a result is loaded into the result register as its final byte
// leaves. Only a final byte waits on the result register: while a finished
// result is held under stall the next string's bytes keep flowing until its
// own final byte arrives. The walk counts whole characters (ASCII, or a C0-F7
// lead plus its 80-BF continuations) and stops at the first invalid byte
// or once the count reaches char_limit; the limit is checked after each
// character, so a limit of zero still keeps one character. Bytes after a
// stop are skipped but still end the string. kept_bytes and kept_chars
// saturate at their maximum. char_limit (reset 0xFFFF) is written through
// the cfg request channel, which is always ready; write it between strings.
// ----------------------------------------------------------------------------
module utf8_prefix_cut_by_char_limit (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // configuration request
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [u8cut_pkg::FIELD_WIDTH-1:0]   cfg_data,
    // byte stream
    input  wire logic                                text_valid,
    output logic                                     text_stall,
    input  wire logic [7:0]                          text_byte,
    input  wire logic                                last_byte,
    // result stream
    output logic                                     result_valid,
    input  wire logic                                result_stall,
    output logic [u8cut_pkg::FIELD_WIDTH-1:0]        kept_bytes,
    output logic [u8cut_pkg::FIELD_WIDTH-1:0]        kept_chars,
    output logic [1:0]                               stop_cause
);
    import u8cut_pkg::*;

    logic [FIELD_WIDTH-1:0] char_limit_reg, char_limit_next;
    logic                   go;
    logic                   res_free;
    byte_item_t             item;
    cut_result_t            result;

    // Limit register
    assign cfg_ready       = 1'b1;
    assign char_limit_next = (cfg_valid && cfg_ready) ? cfg_data : char_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_limit_reg <= FIELD_MAX;
        end
        else
        begin
            char_limit_reg <= char_limit_next;
        end
    end

    u8cut_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_valid (text_valid),
        .text_stall (text_stall),
        .text_byte  (text_byte),
        .last_byte  (last_byte),
        .res_free   (res_free),
        .go         (go),
        .item       (item)
    );

    u8cut_walker u_walker (
        .clk        (clk),
        .rst_n      (rst_n),
        .go         (go),
        .item       (item),
        .char_limit (char_limit_reg),
        .result     (result)
    );

    // A result request is loaded only as a final byte is walked
    u8cut_out_reg u_out_reg (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (go && item.last_byte),
        .result       (result),
        .res_free     (res_free),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .kept_bytes   (kept_bytes),
        .kept_chars   (kept_chars),
        .stop_cause   (stop_cause)
    );

`ifndef SYNTHESIS
    // Input is held back only while a byte sits in the input register
    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        text_stall |-> item.valid)
        else $error("byte stream stalled with empty input register");

    // A non-final byte is never held back
    a_mid_string_flows: assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && !item.last_byte) |-> go)
        else $error("mid-string byte stalled");

    // A walked final byte always shows a result on the next cycle
    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (go && item.last_byte) |=> result_valid)
        else $error("final byte produced no result");
`endif

endmodule : utf8_prefix_cut_by_char_limit
`default_nettype wire

/* sim/u8cut_prefix_checker.sv */
// ----------------------------------------------------------------------------
// u8cut_prefix_checker
// Watches the byte, result and config channels of the UTF-8 prefix cutter,
// predicts each string's kept prefix and compares it with the result port.
// ----------------------------------------------------------------------------
module u8cut_prefix_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [u8cut_pkg::FIELD_WIDTH-1:0] cfg_data,
    input  logic                              text_valid,
    input  logic                              text_stall,
    input  logic [7:0]                        text_byte,
    input  logic                              last_byte,
    input  logic                              result_valid,
    input  logic                              result_stall,
    input  logic [u8cut_pkg::FIELD_WIDTH-1:0] kept_bytes,
    input  logic [u8cut_pkg::FIELD_WIDTH-1:0] kept_chars,
    input  logic [1:0]                        stop_cause,
    output int                                fail_count,
    output int                                results_taken
);
    import u8cut_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic [FIELD_WIDTH-1:0] char_limit;
    logic                   walk_halted;
    logic [1:0]             cont_left;
    logic [2:0]             char_len;
    logic [LEN_WIDTH-1:0]   prefix_len;
    logic [FIELD_WIDTH-1:0] char_total;
    logic [1:0]             halt_cause;

    cut_result_t            prefix_q[$];
    int                     mismatches;

    task automatic clear_walk();
        walk_halted = 1'b0;
        cont_left   = '0;
        char_len    = '0;
        prefix_len  = '0;
        char_total  = '0;
        halt_cause  = CAUSE_END;
    endtask

    task automatic halt_walk(input logic [1:0] cause);
        walk_halted = 1'b1;
        halt_cause  = cause;
    endtask

    // whole character seen: grow the prefix, then test the limit
    task automatic count_char(input logic [2:0] nbytes);
        logic [LEN_WIDTH:0] grown;
        grown      = {1'b0, prefix_len} + (LEN_WIDTH+1)'(nbytes);
        prefix_len = grown[LEN_WIDTH] ? LEN_MAX : grown[LEN_WIDTH-1:0];
        if (char_total != FIELD_MAX)
            char_total = char_total + FIELD_WIDTH'(1);
        cont_left = '0;
        char_len  = '0;
        if (char_limit <= char_total)
            halt_walk(CAUSE_LIMIT);
    endtask

    task automatic walk_byte(input logic [7:0] b);
        if (cont_left == 2'd0)
        begin
            if (b <= ASCII_MAX)
                count_char(3'd1);
            else if (b >= LEAD2_MIN && b <= LEAD2_MAX)
            begin
                cont_left = 2'd1;
                char_len  = 3'd1;
            end
            else if (b >= LEAD3_MIN && b <= LEAD3_MAX)
            begin
                cont_left = 2'd2;
                char_len  = 3'd1;
            end
            else if (b >= LEAD4_MIN && b <= LEAD4_MAX)
            begin
                cont_left = 2'd3;
                char_len  = 3'd1;
            end
            else
                halt_walk(CAUSE_INVALID);
        end
        else if (b >= CONT_MIN && b <= CONT_MAX)
        begin
            char_len  = char_len + 3'd1;
            cont_left = cont_left - 2'd1;
            if (cont_left == 2'd0)
                count_char(char_len);
        end
        else
            halt_walk(CAUSE_INVALID);
    endtask

    task automatic close_string();
        cut_result_t              cut;
        logic [LEN_EXT_WIDTH-1:0] len_ext;
        len_ext        = LEN_EXT_WIDTH'(prefix_len);
        cut.kept_bytes = (len_ext > LEN_EXT_WIDTH'(FIELD_MAX)) ? FIELD_MAX
                                                               : len_ext[FIELD_WIDTH-1:0];
        cut.kept_chars = char_total;
        if (walk_halted)
            cut.stop_cause = halt_cause;
        else if (cont_left != 2'd0)
            cut.stop_cause = CAUSE_TRUNC;
        else
            cut.stop_cause = CAUSE_END;
        prefix_q.insert(prefix_q.size(), cut);
        clear_walk();
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // results are older than any byte taken on the same edge: compare first
    always @(posedge clk or negedge rst_n)
    begin
        cut_result_t want;
        if (!rst_n)
        begin
            char_limit = FIELD_MAX;
            clear_walk();
            prefix_q.delete();
            mismatches = 0;
            results_taken <= 0;
            fail_count    <= 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (prefix_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %0d/%0d/%0d",
                             $time, kept_bytes, kept_chars, stop_cause);
                    mismatches++;
                end
                else
                begin
                    want = prefix_q.pop_front();
                    check_field("kept_bytes", want.kept_bytes, kept_bytes);
                    check_field("kept_chars", want.kept_chars, kept_chars);
                    check_field("stop_cause", want.stop_cause, stop_cause);
                end
                results_taken <= results_taken + 1;
            end
            if (cfg_valid && cfg_ready)
                char_limit = cfg_data;
            if (text_valid && !text_stall)
            begin
                if (!walk_halted)
                    walk_byte(text_byte);
                if (last_byte)
                    close_string();
            end
            fail_count <= mismatches + prefix_q.size();
        end
    end

endmodule : u8cut_prefix_checker

/* sim/utf8_prefix_cut_by_char_limit_tb.sv */
// ----------------------------------------------------------------------------
// utf8_prefix_cut_by_char_limit_tb
// Drives strings of UTF-8 bytes through the prefix cutter under several char
// limits and idle patterns; a checker beside the block predicts every result.
// ----------------------------------------------------------------------------
module utf8_prefix_cut_by_char_limit_tb;
    import u8cut_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // cycles with no request moving on any channel before we give up
    localparam int QUIET_LIMIT = 4000;
    // idle margin after the results are back, before cfg writes
    localparam int DRAIN_CYCLES = 4;

    logic                   clk;
    logic                   rst_n        = 1'b0;
    logic                   cfg_valid    = 1'b0;
    logic [FIELD_WIDTH-1:0] cfg_data     = '0;
    logic                   text_valid   = 1'b0;
    logic [7:0]             text_byte    = '0;
    logic                   last_byte    = 1'b0;
    logic                   result_stall = 1'b0;

    logic                   cfg_ready;
    logic                   text_stall;
    logic                   result_valid;
    logic [FIELD_WIDTH-1:0] kept_bytes;
    logic [FIELD_WIDTH-1:0] kept_chars;
    logic [1:0]             stop_cause;

    int                     fail_count;
    int                     results_taken;

    // stimulus bookkeeping
    int                     send_gap_pct = 17;
    int                     hold_pct     = 88;
    int                     bytes_sent   = 0;
    int                     strings_done = 0;
    int                     quiet_cycles = 0;
    logic [7:0]             text_q[$];

    utf8_prefix_cut_by_char_limit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .text_valid   (text_valid),
        .text_stall   (text_stall),
        .text_byte    (text_byte),
        .last_byte    (last_byte),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .kept_bytes   (kept_bytes),
        .kept_chars   (kept_chars),
        .stop_cause   (stop_cause)
    );

    u8cut_prefix_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .text_valid    (text_valid),
        .text_stall    (text_stall),
        .text_byte     (text_byte),
        .last_byte     (last_byte),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .kept_bytes    (kept_bytes),
        .kept_chars    (kept_chars),
        .stop_cause    (stop_cause),
        .fail_count    (fail_count),
        .results_taken (results_taken)
    );

    // 2 ns clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // result side back-pressure, redrawn every cycle
    always @(posedge clk)
        result_stall <= ($urandom_range(0, 99) < hold_pct);

    // watchdog: reset by any request moving on any channel
    always @(posedge clk)
    begin
        if ((text_valid && !text_stall) || (result_valid && !result_stall) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("utf8_prefix_cut_by_char_limit_tb failed");
        $finish;
    end

    // one byte request, with random idle cycles ahead of it; valid is held
    // high across back-to-back bytes and only dropped on an idle cycle
    task automatic send_byte(input logic [7:0] b, input logic fin);
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            text_valid <= 1'b0;
            @(posedge clk);
        end
        text_valid <= 1'b1;
        text_byte  <= b;
        last_byte  <= fin;
        @(posedge clk);
        while (text_stall)
            @(posedge clk);
        bytes_sent++;
        if (fin)
            strings_done++;
    endtask

    task automatic send_text();
        foreach (text_q[i])
            send_byte(text_q[i], i == text_q.size() - 1);
        text_q.delete();
    endtask

    // sender pauses until every string's result is back, then lets the
    // pipeline empty so the block is idle for a limit write
    task automatic settle();
        text_valid <= 1'b0;
        while (results_taken < strings_done)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [FIELD_WIDTH-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic append_byte(input logic [7:0] b);
        text_q.insert(text_q.size(), b);
    endtask

    // kind 0 ASCII, 1..3 multi-byte lead; conts continuation bytes follow
    task automatic add_char(input int kind, input int conts);
        unique case (kind)
            0:       append_byte(8'($urandom_range(0, ASCII_MAX)));
            1:       append_byte(8'($urandom_range(LEAD2_MIN, LEAD2_MAX)));
            2:       append_byte(8'($urandom_range(LEAD3_MIN, LEAD3_MAX)));
            default: append_byte(8'($urandom_range(LEAD4_MIN, LEAD4_MAX)));
        endcase
        repeat (conts) append_byte(8'($urandom_range(CONT_MIN, CONT_MAX)));
    endtask

    // mostly well-formed strings; the rest are noise, strings cut off
    // mid-character, or strings with one stray byte dropped in
    task automatic build_random_text();
        int shape;
        int chars;
        int kind;
        shape = $urandom_range(0, 99);
        chars = $urandom_range(1, 8);
        if (shape < 8)
            repeat (chars) append_byte(8'($urandom_range(0, 255)));
        else
        begin
            repeat (chars)
            begin
                kind = $urandom_range(0, 3);
                add_char(kind, kind);
            end
            if (shape < 16)
            begin
                kind = $urandom_range(1, 3);
                add_char(kind, $urandom_range(0, kind - 1));
            end
            else if (shape < 24)
                text_q.insert($urandom_range(0, text_q.size()), 8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        int mode;
        int phase;
        int target;
        logic [FIELD_WIDTH-1:0] limit;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed, at the reset limit ----
        // ASCII extremes
        text_q = {8'h00, 8'h7F};
        send_text();
        // 2-byte leads and continuation extremes
        text_q = {8'hC0, 8'h80, 8'hDF, 8'hBF};
        send_text();
        // 3- and 4-byte characters
        text_q = {8'hE0, 8'h80, 8'hBF, 8'hF7, 8'hBF, 8'h80, 8'h80};
        send_text();
        // invalid lead; what follows is ignored but still ends the string
        text_q = {8'hF8, 8'h41, 8'hFF};
        send_text();
        // string ends inside a character
        text_q = {8'hEF, 8'hBF};
        send_text();
        // bad continuation, on the final byte
        text_q = {8'hF0, 8'h41};
        send_text();

        // limit of zero still keeps one character
        settle();
        write_limit('0);
        text_q = {8'h42, 8'h43};
        send_text();

        // limit met exactly on the final byte
        settle();
        write_limit(FIELD_WIDTH'(2));
        text_q = {8'hC3, 8'hA9, 8'h7A};
        send_text();

        // ---- random: three idle patterns, four limits each ----
        for (mode = 0; mode < 3; mode++)
        begin
            unique case (mode)
                0:       begin send_gap_pct = 17; hold_pct = 88; end
                1:       begin send_gap_pct = 88; hold_pct = 17; end
                default: begin send_gap_pct = 0;  hold_pct = 0;  end
            endcase
            for (phase = 0; phase < 4; phase++)
            begin
                unique case (phase)
                    0:       limit = FIELD_WIDTH'($urandom_range(1, 6));
                    1:       limit = '0;
                    2:       limit = FIELD_MAX;
                    default: limit = FIELD_WIDTH'($urandom_range(7, 20));
                endcase
                settle();
                write_limit(limit);
                target = bytes_sent + 70;
                while (bytes_sent < target)
                begin
                    build_random_text();
                    send_text();
                end
            end
        end

        settle();
        if (fail_count == 0)
            $display("utf8_prefix_cut_by_char_limit_tb passed");
        else
            $display("utf8_prefix_cut_by_char_limit_tb failed");
        $finish;
    end

endmodule : utf8_prefix_cut_by_char_limit_tb
